// ===== design/wfba_pkg.sv =====
// Shared types and constants for the worst-fit block allocator.
// No dependencies; every other design file refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package wfba_pkg;

  localparam int NumBlocks = 16;
  localparam int SizeBits  = 16;
  localparam int IdxW      = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int CntW      = $clog2(NumBlocks + 1);
  localparam int CfgW      = 5;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_GRANTED = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FIN
  } back_state_e;

  typedef struct packed {
    logic        mode;
    logic [3:0]  block_index;
    logic [15:0] size_value;
    logic [7:0]  request_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] granted_block;
    logic [7:0] request_echo;
  } out_item_t;

  // Decoded command handed from the front to the back through the queue
  typedef struct packed {
    op_e                 op;
    logic [IdxW-1:0]     idx;
    logic [SizeBits-1:0] size;
    logic [7:0]          id;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/wfba_front.sv =====
// Front end: registers an accepted input transaction and decodes it into a command.
// Depends on wfba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfba_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire wfba_pkg::in_item_t in_data_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output wfba_pkg::cmd_t         cmd_o
);

  logic           vld_q, vld_d;
  wfba_pkg::cmd_t cmd_q, cmd_d;
  logic           in_fire;

  assign in_ready_o = !vld_q || cmd_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_d = cmd_q;
    if (in_fire) begin
      cmd_d.op   = in_data_i.mode ? wfba_pkg::OP_ALLOC : wfba_pkg::OP_LOAD;
      cmd_d.idx  = wfba_pkg::IdxW'(in_data_i.block_index);
      cmd_d.size = wfba_pkg::SizeBits'(in_data_i.size_value);
      cmd_d.id   = in_data_i.request_id;
    end
    vld_d = in_fire ? 1'b1 : (cmd_ready_i ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

// ===== design/wfba_queue.sv =====
// Short command queue decoupling the front end from the allocation engine.
// Depends on wfba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfba_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire wfba_pkg::cmd_t  push_data_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output wfba_pkg::cmd_t       pop_data_o
);

  wfba_pkg::cmd_t                 mem_q [wfba_pkg::QDepth];
  logic [wfba_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [wfba_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           push, pop;

  assign push_ready_o = (cnt_q != wfba_pkg::QCntW'(wfba_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= wfba_pkg::QCntW'(wfba_pkg::QDepth))
    else $error("queue occupancy beyond depth");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q == wfba_pkg::QCntW'(wfba_pkg::QDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with occupancy");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue occupancy did not follow a push");
`endif

endmodule

`default_nettype wire

// ===== design/wfba_back.sv =====
// Allocation engine: block size memory, taken flags, serial worst-fit scan and
// output register. Depends on wfba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfba_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [wfba_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic                      cmd_valid_i,
  output logic                           cmd_ready_o,
  input  wire wfba_pkg::cmd_t            cmd_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output wfba_pkg::out_item_t            out_data_o
);

  logic [wfba_pkg::SizeBits-1:0] size_mem [wfba_pkg::NumBlocks];
  logic [wfba_pkg::NumBlocks-1:0] taken_q, taken_d;

  logic [wfba_pkg::CfgW-1:0]     blk_cnt_q;
  wfba_pkg::back_state_e         state_q, state_d;
  logic [wfba_pkg::CntW-1:0]     limit_q, limit_d;
  logic [wfba_pkg::CntW-1:0]     scan_q, scan_d;
  logic                          pend_q, pend_d;
  logic [wfba_pkg::IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [wfba_pkg::SizeBits-1:0] rd_data_q;
  logic                          found_q, found_d;
  logic [wfba_pkg::IdxW-1:0]     best_idx_q, best_idx_d;
  logic [wfba_pkg::SizeBits-1:0] best_size_q, best_size_d;
  logic [wfba_pkg::SizeBits-1:0] req_size_q, req_size_d;
  logic [7:0]                    req_id_q, req_id_d;
  logic                          out_vld_q, out_vld_d;
  wfba_pkg::out_item_t           out_q, out_d;

  logic slot_free, pop, rd_en, load_we, fin_fire, cand;

  assign slot_free   = !out_vld_q || out_ready_i;
  assign cmd_ready_o = (state_q == wfba_pkg::BK_IDLE) && slot_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign load_we     = pop && (cmd_i.op == wfba_pkg::OP_LOAD);
  assign fin_fire    = (state_q == wfba_pkg::BK_FIN) && slot_free;
  assign rd_en       = (state_q == wfba_pkg::BK_SCAN) && (scan_q != limit_q);

  // Candidate check on the entry read in the previous cycle
  assign cand = pend_q && !taken_q[cmp_idx_q] && (rd_data_q >= req_size_q);

  always_comb begin
    state_d     = state_q;
    limit_d     = limit_q;
    scan_d      = scan_q;
    pend_d      = rd_en;
    cmp_idx_d   = scan_q[wfba_pkg::IdxW-1:0];
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    req_size_d  = req_size_q;
    req_id_d    = req_id_q;
    taken_d     = taken_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      wfba_pkg::BK_IDLE: begin
        if (pop) begin
          if (cmd_i.op == wfba_pkg::OP_LOAD) begin
            taken_d[cmd_i.idx]  = 1'b0;
            out_vld_d           = 1'b1;
            out_d.status        = wfba_pkg::ST_LOADED;
            out_d.granted_block = '0;
            out_d.request_echo  = cmd_i.id;
          end else begin
            // block_count saturates at the table depth
            if (wfba_pkg::CntW'(blk_cnt_q) > wfba_pkg::CntW'(wfba_pkg::NumBlocks)) begin
              limit_d = wfba_pkg::CntW'(wfba_pkg::NumBlocks);
            end else begin
              limit_d = wfba_pkg::CntW'(blk_cnt_q);
            end
            scan_d     = '0;
            found_d    = 1'b0;
            req_size_d = cmd_i.size;
            req_id_d   = cmd_i.id;
            state_d    = wfba_pkg::BK_SCAN;
          end
        end
      end
      wfba_pkg::BK_SCAN: begin
        if (rd_en) begin
          scan_d = scan_q + 1'b1;
        end
        // strict greater keeps the lowest index on a tie
        if (cand && (!found_q || (rd_data_q > best_size_q))) begin
          found_d     = 1'b1;
          best_idx_d  = cmp_idx_q;
          best_size_d = rd_data_q;
        end
        if (!rd_en && !pend_q) begin
          state_d = wfba_pkg::BK_FIN;
        end
      end
      wfba_pkg::BK_FIN: begin
        if (fin_fire) begin
          out_vld_d          = 1'b1;
          out_d.request_echo = req_id_q;
          if (found_q) begin
            taken_d[best_idx_q] = 1'b1;
            out_d.status        = wfba_pkg::ST_GRANTED;
            out_d.granted_block = 4'(best_idx_q);
          end else begin
            out_d.status        = wfba_pkg::ST_REFUSED;
            out_d.granted_block = '0;
          end
          state_d = wfba_pkg::BK_IDLE;
        end
      end
      default: state_d = wfba_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wfba_pkg::BK_IDLE;
      blk_cnt_q <= '0;
      taken_q   <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      scan_q    <= '0;
      limit_q   <= '0;
    end else begin
      state_q   <= state_d;
      taken_q   <= taken_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
      found_q   <= found_d;
      scan_q    <= scan_d;
      limit_q   <= limit_d;
      if (cfg_we_i) begin
        blk_cnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    req_size_q  <= req_size_d;
    req_id_q    <= req_id_d;
    out_q       <= out_d;
  end

  // Size table: one write port for loads, one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      size_mem[cmd_i.idx] <= cmd_i.size;
    end
    if (rd_en) begin
      rd_data_q <= size_mem[scan_q[wfba_pkg::IdxW-1:0]];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wfba_pkg::BK_SCAN |-> scan_q <= limit_q)
    else $error("scan index ran past block count");
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire && found_q |-> wfba_pkg::CntW'(best_idx_q) < limit_q)
    else $error("granted block outside scanned range");
  a_grant_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire && found_q |=> taken_q[$past(best_idx_q)])
    else $error("granted block not marked taken");
  a_grant_was_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire && found_q |-> !taken_q[best_idx_q])
    else $error("granted block was already taken");
`endif

endmodule

`default_nettype wire

// ===== design/worst_fit_block_allocator_core.sv =====
// Top level of the worst-fit block allocator: front end, command queue and
// allocation engine. Depends on wfba_pkg, wfba_front, wfba_queue, wfba_back.
`timescale 1ns / 1ps
`default_nettype none

// Worst-fit allocator over a table of 16 blocks of 16-bit size. A load
// transaction writes one block's size and frees it; an allocate transaction
// picks the largest free block of at least the requested size among the first
// block_count entries (lowest index on a tie), marks it taken and returns its
// index, or a refusal. Every input transaction gives one result. The engine
// handles one command at a time: a load is done as it is taken from the queue;
// an allocation runs a serial scan of min(block_count, 16) entries through the
// single read port of the size table (one entry per cycle), then drains the
// last read and registers the result. The front register and the two-entry
// queue sit ahead of the engine and let inputs be taken while the engine is
// busy. The engine takes a command only when the output register is empty or
// being emptied, so a stalled receiver stalls it. Write block_count only when
// no transaction is in flight.
module worst_fit_block_allocator_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire wfba_pkg::in_item_t        in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output wfba_pkg::out_item_t            out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [wfba_pkg::CfgW-1:0] cfg_data_i
);

  logic           f_valid, f_ready, b_valid, b_ready;
  wfba_pkg::cmd_t f_cmd, b_cmd;

  wfba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  wfba_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  wfba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
